/* sv/scanned_occupancy_debouncer_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the scanned occupancy debouncer
// Short wrappers for concurrent assertions clocked on clk and held off in rst.
// ----------------------------------------------------------------------------
`ifndef SCANNED_OCCUPANCY_DEBOUNCER_TOP_ASSERT_SVH
`define SCANNED_OCCUPANCY_DEBOUNCER_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define SOD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scanned occupancy debouncer check failed");

// Consequent checked in the cycle after the antecedent.
`define SOD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scanned occupancy debouncer check failed");

`endif

/* sv/sod_pkg.sv */
// ----------------------------------------------------------------------------
// sod_pkg
// Shared widths, constants, register indexes and types of the debouncer.
// ----------------------------------------------------------------------------
package sod_pkg;

  localparam int MAX_BANKS_DEFAULT         = 4;
  localparam int CHANNELS_PER_BANK_DEFAULT = 8;
  localparam int SLOT_STRIDE               = 8;
  localparam int BLOCK_W                   = 3;

  localparam int SAMPLE_W  = 10;
  localparam int TIME_W    = 32;
  localparam int SUM_W     = 14;
  localparam int COUNT_W   = 5;
  localparam int TAKEN_W   = 4;
  localparam int CHANNEL_W = 5;
  localparam int LIMIT_W   = 12;

  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int DEBOUNCE_W  = 16;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [LIMIT_W-1:0] OCCUPIED_LIMIT = 12'd150;
  localparam logic [COUNT_W-1:0] MAX_SAMPLES    = 5'd16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_BANK_COUNT   = 2'd0,
    REG_SAMPLE_COUNT = 2'd1,
    REG_DEBOUNCE_MS  = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [2:0]            bank_count;
    logic [COUNT_W-1:0]    sample_count;
    logic [DEBOUNCE_W-1:0] debounce_ms;
  } cfg_t;

  localparam logic [2:0]            BANK_COUNT_RESET   = 3'd1;
  localparam logic [COUNT_W-1:0]    SAMPLE_COUNT_RESET = 5'd4;
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_MS_RESET  = 16'd50;

endpackage

/* sv/sod_ram.sv */
// ----------------------------------------------------------------------------
// sod_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sod_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/sod_front.sv */
// ----------------------------------------------------------------------------
// sod_front
// Accumulates readings of the scanned channel and emits one visit record.
// ----------------------------------------------------------------------------
module sod_front
  import sod_pkg::*;
#(
  parameter int MAX_BANKS         = MAX_BANKS_DEFAULT,
  parameter int CHANNELS_PER_BANK = CHANNELS_PER_BANK_DEFAULT,
  parameter int SLOT_W            = $clog2(MAX_BANKS * SLOT_STRIDE),
  parameter int REC_W             = SLOT_W + 1 + TIME_W
) (
  input  logic                clk,
  input  logic                rst,
  input  cfg_t                cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [SAMPLE_W-1:0] adc_sample,
  input  logic [TIME_W-1:0]   time_ms,
  input  logic                full,
  output logic                push,
  output logic [REC_W-1:0]    push_data
);

  localparam int BANK_W  = (MAX_BANKS > 1) ? $clog2(MAX_BANKS) : 1;
  localparam int BANKS_W = $clog2(MAX_BANKS + 1);

  logic [BANK_W-1:0]  scan_bank;
  logic [BLOCK_W-1:0] scan_block;
  logic [SUM_W-1:0]   sample_sum;
  logic [TAKEN_W-1:0] samples_taken;

  logic               take;
  logic [COUNT_W-1:0] n;
  logic [BANKS_W-1:0] banks;
  logic [BANK_W-1:0]  bank_use;
  logic [BLOCK_W-1:0] block_use;
  logic [SUM_W-1:0]   sum_next;
  logic [COUNT_W-1:0] taken_next;
  logic               last;
  logic [LIMIT_W-1:0] limit;
  logic               occ;
  logic [SLOT_W-1:0]  slot;
  logic [BANK_W-1:0]  bank_next;
  logic [BLOCK_W-1:0] block_next;

  assign in_ready = !full;
  assign take     = in_valid && in_ready;

  always_comb begin
    if (cfg.sample_count == '0) begin
      n = COUNT_W'(1);
    end else if (cfg.sample_count > MAX_SAMPLES) begin
      n = MAX_SAMPLES;
    end else begin
      n = cfg.sample_count;
    end

    if (cfg.bank_count == '0) begin
      banks = BANKS_W'(1);
    end else if (32'(cfg.bank_count) > MAX_BANKS) begin
      banks = BANKS_W'(MAX_BANKS);
    end else begin
      banks = BANKS_W'(cfg.bank_count);
    end

    // A position left over from a larger bank count wraps to bank zero.
    bank_use  = (32'(scan_bank) >= 32'(banks)) ? '0 : scan_bank;
    block_use = (32'(scan_block) >= CHANNELS_PER_BANK) ? '0 : scan_block;

    sum_next   = sample_sum + SUM_W'(adc_sample);
    taken_next = COUNT_W'(samples_taken) + COUNT_W'(1);
    last       = (taken_next >= n);
    limit      = LIMIT_W'(16'(OCCUPIED_LIMIT) * 16'(n));
    occ        = (sum_next < SUM_W'(limit));
    slot       = SLOT_W'(32'(bank_use) * SLOT_STRIDE + 32'(block_use));

    if (32'(block_use) + 1 >= CHANNELS_PER_BANK) begin
      block_next = '0;
      bank_next  = (32'(bank_use) + 1 >= 32'(banks)) ? '0 : BANK_W'(32'(bank_use) + 1);
    end else begin
      block_next = BLOCK_W'(32'(block_use) + 1);
      bank_next  = bank_use;
    end
  end

  assign push      = take && last;
  assign push_data = {slot, occ, time_ms};

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_bank     <= '0;
      scan_block    <= '0;
      sample_sum    <= '0;
      samples_taken <= '0;
    end else if (take) begin
      if (last) begin
        sample_sum    <= '0;
        samples_taken <= '0;
        scan_bank     <= bank_next;
        scan_block    <= block_next;
      end else begin
        sample_sum    <= sum_next;
        samples_taken <= taken_next[TAKEN_W-1:0];
      end
    end
  end

endmodule

/* sv/sod_queue.sv */
// ----------------------------------------------------------------------------
// sod_queue
// Short first-in first-out queue of visit records between front and back.
// ----------------------------------------------------------------------------
module sod_queue
  import sod_pkg::*;
#(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic             full,
  output logic             not_empty,
  output logic [WIDTH-1:0] head
);

  localparam int PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0]   slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [COUNT_W-1:0] count;

  assign full      = (32'(count) == QUEUE_DEPTH);
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (32'(wr_ptr) == QUEUE_DEPTH - 1) ? '0 : PTR_W'(32'(wr_ptr) + 1);
      end
      if (pop) begin
        rd_ptr <= (32'(rd_ptr) == QUEUE_DEPTH - 1) ? '0 : PTR_W'(32'(rd_ptr) + 1);
      end
      if (push && !pop) begin
        count <= count + COUNT_W'(1);
      end else if (pop && !push) begin
        count <= count - COUNT_W'(1);
      end
    end
  end

endmodule

/* sv/sod_back.sv */
// ----------------------------------------------------------------------------
// sod_back
// Per-channel debounce update: read, judge and write back one channel record.
// ----------------------------------------------------------------------------
module sod_back
  import sod_pkg::*;
#(
  parameter int MAX_BANKS = MAX_BANKS_DEFAULT,
  parameter int SLOT_W    = $clog2(MAX_BANKS * SLOT_STRIDE),
  parameter int REC_W     = SLOT_W + 1 + TIME_W
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [DEBOUNCE_W-1:0] debounce_ms,
  input  logic                  head_valid,
  input  logic [REC_W-1:0]      head_data,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CHANNEL_W-1:0]  channel,
  output logic                  changed,
  output logic                  occupied
);

  localparam int DEPTH   = MAX_BANKS * SLOT_STRIDE;
  localparam int ENTRY_W = 2 + TIME_W;

  // Record entry layout: raw state, debounced state, time of last raw change.
  logic [SLOT_W-1:0]  h_slot;
  logic               h_occ;
  logic [TIME_W-1:0]  h_now;

  logic               a_valid;
  logic [SLOT_W-1:0]  a_slot;
  logic               a_occ;
  logic [TIME_W-1:0]  a_now;
  logic               a_hit;
  logic [ENTRY_W-1:0] a_fwd;
  logic               a_known;

  logic [DEPTH-1:0]   written;
  logic [ENTRY_W-1:0] rdata;
  logic [ENTRY_W-1:0] cur;
  logic [ENTRY_W-1:0] entry_next;
  logic               changed_next;
  logic               retire;
  logic               cur_raw;
  logic               cur_stable;
  logic [TIME_W-1:0]  cur_time;
  logic [TIME_W-1:0]  held;

  assign h_slot = head_data[REC_W-1 -: SLOT_W];
  assign h_occ  = head_data[TIME_W];
  assign h_now  = head_data[TIME_W-1:0];

  assign retire = a_valid && (!out_valid || out_ready);
  assign pop    = head_valid && (!a_valid || retire);

  sod_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_records (
    .clk   (clk),
    .we    (retire),
    .waddr (a_slot),
    .wdata (entry_next),
    .re    (pop),
    .raddr (h_slot),
    .rdata (rdata)
  );

  always_comb begin
    if (a_hit) begin
      cur = a_fwd;
    end else if (a_known) begin
      cur = rdata;
    end else begin
      cur = '0;
    end
    cur_raw      = cur[ENTRY_W-1];
    cur_stable   = cur[ENTRY_W-2];
    cur_time     = cur[TIME_W-1:0];
    held         = a_now - cur_time;
    changed_next = 1'b0;
    entry_next   = cur;
    if (cur_raw != a_occ) begin
      entry_next = {a_occ, cur_stable, a_now};
    end else if (held > TIME_W'(debounce_ms)) begin
      if (cur_stable != a_occ) begin
        entry_next   = {cur_raw, a_occ, cur_time};
        changed_next = 1'b1;
      end
    end
  end

  // Stage holding the record whose entry read is in flight.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      written <= '0;
    end else begin
      if (pop) begin
        a_valid <= 1'b1;
      end else if (retire) begin
        a_valid <= 1'b0;
      end
      if (retire) begin
        written[a_slot] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      a_slot  <= h_slot;
      a_occ   <= h_occ;
      a_now   <= h_now;
      a_known <= written[h_slot];
      // The entry written this cycle is not yet visible at the read port.
      a_hit   <= retire && (h_slot == a_slot);
      a_fwd   <= entry_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (retire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (retire) begin
      channel  <= CHANNEL_W'(a_slot);
      changed  <= changed_next;
      occupied <= a_occ;
    end
  end

endmodule

/* sv/scanned_occupancy_debouncer_top.sv */
// ----------------------------------------------------------------------------
// scanned_occupancy_debouncer_top
// Scanned occupancy detector with per-channel debounce over up to 32 channels.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): each transfer carries one converter
// reading of the channel under scan and its millisecond time stamp. Readings
// are summed until sample_count of them have arrived; the visit then ends.
// Output channel (out_valid/out_ready): one transfer per finished visit with
// the channel number, its raw occupied judgement and a flag that is set when
// the debounced state of that channel changed on this visit.
// Rate: one reading per cycle while the record queue is not full. The
// record of each visit passes through the record queue and the registered
// read of the channel record memory before its result reaches the output.
// That memory can start a new visit while the last one retires, and a
// visit to the channel just updated is served from a bypass register.
// When the receiver stalls, the result waits in the output register, the
// update stage and the two-entry record queue; only when the queue is full
// does in_ready drop. Reset returns the scan to channel 0, clears the
// running sum, empties the queue and marks every channel record unwritten,
// so all channels read as released with a zero change time. No clearing
// pass is needed. Register writes on the cfg port take effect at once.
// ----------------------------------------------------------------------------
module scanned_occupancy_debouncer_top
  import sod_pkg::*;
#(
  parameter int MAX_BANKS         = MAX_BANKS_DEFAULT,
  parameter int CHANNELS_PER_BANK = CHANNELS_PER_BANK_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_W-1:0]    adc_sample,
  input  logic [TIME_W-1:0]      time_ms,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [CHANNEL_W-1:0]   channel,
  output logic                   changed,
  output logic                   occupied
);

  // A slot is bank * 8 + channel within the bank, so each bank owns 8 slots.
  localparam int SLOT_W = $clog2(MAX_BANKS * SLOT_STRIDE);
  localparam int REC_W  = SLOT_W + 1 + TIME_W;

  cfg_t             cfg;
  logic             push;
  logic [REC_W-1:0] push_data;
  logic             full;
  logic             head_valid;
  logic [REC_W-1:0] head_data;
  logic             pop;

  // Configuration registers. An index past the register list is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bank_count   <= BANK_COUNT_RESET;
      cfg.sample_count <= SAMPLE_COUNT_RESET;
      cfg.debounce_ms  <= DEBOUNCE_MS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_BANK_COUNT: begin
          cfg.bank_count <= cfg_data[2:0];
        end
        REG_SAMPLE_COUNT: begin
          cfg.sample_count <= cfg_data[COUNT_W-1:0];
        end
        REG_DEBOUNCE_MS: begin
          cfg.debounce_ms <= cfg_data[DEBOUNCE_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Front: accumulation and scan position; emits one record per visit.
  sod_front #(
    .MAX_BANKS         (MAX_BANKS),
    .CHANNELS_PER_BANK (CHANNELS_PER_BANK),
    .SLOT_W            (SLOT_W),
    .REC_W             (REC_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .adc_sample (adc_sample),
    .time_ms    (time_ms),
    .full       (full),
    .push       (push),
    .push_data  (push_data)
  );

  // Queue decouples the front from stalls at the output.
  sod_queue #(
    .WIDTH (REC_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .full      (full),
    .not_empty (head_valid),
    .head      (head_data)
  );

  // Back: per-channel record update and the output register.
  sod_back #(
    .MAX_BANKS (MAX_BANKS),
    .SLOT_W    (SLOT_W),
    .REC_W     (REC_W)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .debounce_ms (cfg.debounce_ms),
    .head_valid  (head_valid),
    .head_data   (head_data),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .channel     (channel),
    .changed     (changed),
    .occupied    (occupied)
  );

endmodule

/* sv/sod_checker.sv */
// ----------------------------------------------------------------------------
// sod_checker
// Port-level checks of the debouncer, bound to the top level.
// ----------------------------------------------------------------------------
`include "scanned_occupancy_debouncer_top_assert.svh"

module sod_checker
  import sod_pkg::*;
#(
  parameter int CHANNELS_PER_BANK = CHANNELS_PER_BANK_DEFAULT
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [CHANNEL_W-1:0] channel,
  input logic                 changed,
  input logic                 occupied
);

  // All result fields side by side, so that one stability check covers them.
  logic [CHANNEL_W+1:0] out_fields;

  assign out_fields = {channel, changed, occupied};

  // The first cycle after reset shows no result.
  `SOD_ASSERT_NOW(a_reset_empty, $past(rst), !out_valid)

  // A result that is not taken stays put.
  `SOD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_fields))

  // The reported channel lies within its bank.
  `SOD_ASSERT_NOW(a_block_range, out_valid, 32'(channel[2:0]) < CHANNELS_PER_BANK)

  // Input back-pressure only follows a stall at the output.
  `SOD_ASSERT_NOW(a_ready_cause, $fell(in_ready), $past(out_valid && !out_ready))

endmodule

bind scanned_occupancy_debouncer_top sod_checker #(
  .CHANNELS_PER_BANK (CHANNELS_PER_BANK)
) u_sod_checker (.*);

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// Scanned occupancy debouncer testbench
// Drives converter readings into the debouncer under random handshake
// pressure, predicts every channel report and checks each one field by field.
// ----------------------------------------------------------------------------
module tb;
  import sod_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Index 3 fits the register index port but names no register, so a write
  // to it must leave every setting alone.
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

  // Pause after the last report before a register write, covering the record
  // queue and the registered memory read, with some margin for a reading
  // still being summed.
  localparam int WRITE_SETTLE = 4;
  // Cycles of silence allowed on both channels before the run is abandoned.
  // The longest intended silence is the receiver hold-off.
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_OFF_CYCLES = 300;

  // One report of a finished channel visit, as it appears on the output.
  typedef struct packed {
    logic [CHANNEL_W-1:0] channel;
    logic                 changed;
    logic                 occupied;
  } occupancy_report_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [SAMPLE_W-1:0]    adc_sample = '0;
  logic [TIME_W-1:0]      time_ms = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [CHANNEL_W-1:0]   channel;
  logic                   changed;
  logic                   occupied;

  scanned_occupancy_debouncer_top dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Scan and debounce predictor. It mirrors the register settings, the scan
  // position, the running sum of the visit and the per-channel records.
  // --------------------------------------------------------------------------
  cfg_t                   reg_shadow;
  logic [1:0]             at_bank;
  logic [BLOCK_W-1:0]     at_block;
  logic [SUM_W-1:0]       visit_sum;
  logic [COUNT_W-1:0]     visit_readings;
  logic                   raw_occ [0:31];
  logic [TIME_W-1:0]      raw_since [0:31];
  logic                   settled_occ [0:31];

  occupancy_report_t      pending_reports [$];
  occupancy_report_t      expected_report;
  int                     mismatch_count = 0;
  int                     quiet_cycles = 0;

  // Handshake pressure, in percent of cycles spent idle on each side.
  int                     send_idle_pct = 0;
  int                     recv_idle_pct = 0;
  int                     hold_request = 0;
  int                     hold_left = 0;

  // Stimulus shaping: the level each channel is being driven toward, how the
  // current visit is filled and the running millisecond clock of the sensor.
  logic                   wanted_occ [0:31];
  int                     visit_style;
  logic [TIME_W-1:0]      sensor_time;

  function automatic int unsigned samples_per_visit();
    if (reg_shadow.sample_count == 0) return 1;
    if (reg_shadow.sample_count > 16) return 16;
    return reg_shadow.sample_count;
  endfunction

  function automatic int unsigned banks_in_use();
    if (reg_shadow.bank_count == 0) return 1;
    if (reg_shadow.bank_count > MAX_BANKS_DEFAULT) return MAX_BANKS_DEFAULT;
    return reg_shadow.bank_count;
  endfunction

  // A stale bank position, left over from a larger bank count, folds back to
  // bank 0 before the channel is used.
  function automatic logic [CHANNEL_W-1:0] channel_under_scan();
    logic [1:0] bank;
    bank = (int'(at_bank) >= int'(banks_in_use())) ? 2'd0 : at_bank;
    return {bank, at_block};
  endfunction

  task automatic reset_predictor();
    reg_shadow.bank_count   = BANK_COUNT_RESET;
    reg_shadow.sample_count = SAMPLE_COUNT_RESET;
    reg_shadow.debounce_ms  = DEBOUNCE_MS_RESET;
    at_bank        = '0;
    at_block       = '0;
    visit_sum      = '0;
    visit_readings = '0;
    for (int i = 0; i < 32; i++) begin
      raw_occ[i]     = 1'b0;
      raw_since[i]   = '0;
      settled_occ[i] = 1'b0;
      wanted_occ[i]  = 1'b0;
    end
  endtask

  // Adds one accepted reading to the visit. On the last reading of the visit
  // the channel is judged, its records updated and a report is queued.
  task automatic judge_reading(logic [SAMPLE_W-1:0] adc, logic [TIME_W-1:0] stamp);
    occupancy_report_t    report;
    logic [CHANNEL_W-1:0] slot;
    logic [TIME_W-1:0]    held;
    int unsigned          n;
    int                   next_bank;
    n = samples_per_visit();
    visit_sum = visit_sum + SUM_W'(adc);
    visit_readings = visit_readings + 1'b1;
    if (visit_readings < n) return;
    slot = channel_under_scan();
    at_bank = slot[CHANNEL_W-1:BLOCK_W];
    report.channel  = slot;
    report.changed  = 1'b0;
    report.occupied = (32'(visit_sum) < 32'(OCCUPIED_LIMIT) * n);
    // A raw change only restarts the timer; the debounced state can move on
    // a later visit once the raw state has held long enough.
    if (raw_occ[slot] != report.occupied) begin
      raw_occ[slot]   = report.occupied;
      raw_since[slot] = stamp;
    end else begin
      held = stamp - raw_since[slot];
      if (held > TIME_W'(reg_shadow.debounce_ms) && settled_occ[slot] != report.occupied) begin
        settled_occ[slot] = report.occupied;
        report.changed    = 1'b1;
      end
    end
    pending_reports.push_back(report);
    visit_sum      = '0;
    visit_readings = '0;
    if (at_block == BLOCK_W'(CHANNELS_PER_BANK_DEFAULT - 1)) begin
      at_block  = '0;
      next_bank = int'(at_bank) + 1;
      if (next_bank >= int'(banks_in_use())) next_bank = 0;
      at_bank = next_bank[1:0];
    end else begin
      at_block = at_block + 1'b1;
    end
  endtask

  // --------------------------------------------------------------------------
  // Input side. Each call offers one reading and returns at the rising edge
  // where it was transferred. Valid is raised at a falling edge and held with
  // a steady payload until in_ready is seen high at a rising edge.
  // --------------------------------------------------------------------------
  task automatic send_reading(logic [SAMPLE_W-1:0] adc, logic [TIME_W-1:0] stamp);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    adc_sample <= adc;
    time_ms    <= stamp;
    do @(posedge clk); while (!in_ready);
    judge_reading(adc, stamp);
  endtask

  // Stops offering readings and waits for every queued report to come out.
  task automatic wait_reports_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  // A reading that ends no visit leaves nothing to wait for, so a short pause
  // follows the drain before any register is touched.
  task automatic settle_before_write();
    wait_reports_drained();
    repeat (WRITE_SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    // Only the low bits of each register are kept.
    case (idx)
      REG_BANK_COUNT:   reg_shadow.bank_count   = data[2:0];
      REG_SAMPLE_COUNT: reg_shadow.sample_count = data[COUNT_W-1:0];
      REG_DEBOUNCE_MS:  reg_shadow.debounce_ms  = data[DEBOUNCE_W-1:0];
      default: ;
    endcase
  endtask

  // Random scan traffic. Each channel is steered toward a level that flips
  // now and then, so raw states hold across visits and the debounce timer
  // gets to fire. Some visits are pure noise and some sit on the threshold.
  // Time advances so that a full scan round spans about the debounce time,
  // with a rare jump anywhere in the 32-bit range.
  task automatic run_traffic(int readings);
    logic [CHANNEL_W-1:0] slot;
    logic [SAMPLE_W-1:0]  adc;
    int unsigned          step_max;
    step_max = (3 * int'(reg_shadow.debounce_ms)) /
               (8 * banks_in_use() * samples_per_visit()) + 1;
    for (int i = 0; i < readings; i++) begin
      slot = channel_under_scan();
      if (visit_readings == 0) begin
        if ($urandom_range(99) < 20) wanted_occ[slot] = !wanted_occ[slot];
        visit_style = $urandom_range(99);
      end
      if (visit_style < 10) adc = SAMPLE_W'($urandom_range(1023));
      else if (visit_style < 25) adc = SAMPLE_W'($urandom_range(153, 147));
      else if (wanted_occ[slot]) adc = SAMPLE_W'($urandom_range(149, 0));
      else adc = SAMPLE_W'($urandom_range(1023, 150));
      if ($urandom_range(99) == 0) sensor_time = $urandom;
      else sensor_time = sensor_time + $urandom_range(step_max);
      send_reading(adc, sensor_time);
    end
  endtask

  // Writes all three registers, junk in the unused upper bits, and runs
  // traffic. Half the phases start just short of the time stamp wrap.
  task automatic run_phase(logic [2:0] banks, logic [COUNT_W-1:0] samples,
                           logic [DEBOUNCE_W-1:0] hold_ms, int readings);
    settle_before_write();
    write_reg(REG_BANK_COUNT, {13'($urandom), banks});
    write_reg(REG_SAMPLE_COUNT, {11'($urandom), samples});
    write_reg(REG_DEBOUNCE_MS, hold_ms);
    if ($urandom_range(1) == 1) sensor_time = 32'hFFFF_FFFF - $urandom_range(5000);
    else sensor_time = $urandom;
    run_traffic(readings);
  endtask

  // --------------------------------------------------------------------------
  // Output side. The ready pattern changes at falling edges; a requested
  // hold-off is counted down here at each falling edge.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Report checker and watchdog. Every transfer on the output is matched
  // against the oldest queued report. The watchdog ends the run when neither
  // channel has moved for too long.
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (out_valid && out_ready) begin
        if (pending_reports.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected report, expected none, %s %0d changed %0b occupied %0b",
                   $time, "actual channel", channel, changed, occupied);
        end else begin
          expected_report = pending_reports.pop_front();
          if (channel !== expected_report.channel) begin
            mismatch_count++;
            $display("%0t: channel mismatch, expected %0d, actual %0d",
                     $time, expected_report.channel, channel);
          end
          if (changed !== expected_report.changed) begin
            mismatch_count++;
            $display("%0t: changed mismatch on channel %0d, expected %0b, actual %0b",
                     $time, expected_report.channel, expected_report.changed, changed);
          end
          if (occupied !== expected_report.occupied) begin
            mismatch_count++;
            $display("%0t: occupied mismatch on channel %0d, expected %0b, actual %0b",
                     $time, expected_report.channel, expected_report.occupied, occupied);
          end
        end
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset settings: four readings per visit on one bank. Extreme readings and
  // time stamps, with the stamp varying inside a visit so that only the last
  // one counts as the visit time.
  task automatic test_reset_defaults();
    send_reading(10'd0, 32'hFFFF_FFFF);
    send_reading(10'd0, 32'd5);
    send_reading(10'd0, 32'd9);
    send_reading(10'd0, 32'd40);
    send_reading(10'd1023, 32'd0);
    send_reading(10'd1023, 32'd0);
    send_reading(10'd1023, 32'd0);
    send_reading(10'd1023, 32'hFFFF_FFFF);
  endtask

  // Register corner cases: a write to the unused index, zero sample and bank
  // counts with junk upper bits, zero debounce, a sum exactly on the threshold,
  // a sample count lowered in the middle of a visit and a bank count above the
  // limit.
  task automatic test_register_corners();
    settle_before_write();
    write_reg(REG_SPARE, 16'hFFFF);
    write_reg(REG_SAMPLE_COUNT, 16'hFFE0);
    write_reg(REG_BANK_COUNT, 16'hFFF8);
    write_reg(REG_DEBOUNCE_MS, 16'h0000);
    for (int i = 0; i < 8; i++) send_reading(10'd149, 32'd100 + i);
    send_reading(10'd150, 32'd200);
    settle_before_write();
    write_reg(REG_SAMPLE_COUNT, 16'd16);
    send_reading(10'd1023, 32'd300);
    send_reading(10'd1023, 32'd301);
    send_reading(10'd0, 32'd302);
    settle_before_write();
    // The visit already holds three readings, so the next one finishes it.
    write_reg(REG_SAMPLE_COUNT, 16'd2);
    send_reading(10'd0, 32'd303);
    settle_before_write();
    write_reg(REG_BANK_COUNT, 16'd7);
  endtask

  task automatic test_receiver_stalls();
    send_idle_pct = 14;
    recv_idle_pct = 76;
    run_phase(3'd1, 5'd1, 16'd0, 150);
    run_phase(3'd4, 5'd4, 16'd50, 200);
  endtask

  // Going from four banks down to fewer leaves the scan position beyond the
  // banks in use about half the time, which exercises the fold back to bank 0.
  task automatic test_sender_gaps();
    send_idle_pct = 76;
    recv_idle_pct = 14;
    run_phase(3'd0, 5'd0, 16'hFFFF, 150);
    run_phase(3'd7, 5'd31, 16'd10, 150);
    run_phase(3'd2, 5'd3, 16'd1, 200);
  endtask

  task automatic test_full_rate();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(3'd3, 5'd2, 16'd20, 250);
    run_phase(3'd4, 5'd16, 16'd200, 150);
    run_phase(3'd1, 5'd5, 16'd5, 200);
  endtask

  // One report per reading while the receiver holds off for a long stretch:
  // the output register, update stage and record queue fill and in_ready
  // must drop until the receiver comes back.
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(3'd2, 5'd1, 16'd3, 10);
    hold_request = HOLD_OFF_CYCLES;
    run_traffic(50);
  endtask

  // The sender stops in the middle of a visit until every report is out,
  // then carries on with the same visit.
  task automatic test_drain_pause();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(3'd4, 5'd2, 16'd100, 31);
    wait_reports_drained();
    run_traffic(30);
  endtask

  initial begin
    reset_predictor();
    send_idle_pct = 14;
    recv_idle_pct = 76;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_register_corners();
    test_receiver_stalls();
    test_sender_gaps();
    test_full_rate();
    test_output_backpressure();
    test_drain_pause();

    // Let the last reports out, then watch a little longer for strays.
    wait_reports_drained();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+sv
sv/sod_pkg.sv
sv/sod_ram.sv
sv/sod_front.sv
sv/sod_queue.sv
sv/sod_back.sv
sv/scanned_occupancy_debouncer_top.sv
sv/sod_checker.sv
dv/tb.sv
